// ===== rtl/ccrm_pkg.sv =====
// Shared types, register indexes and helper functions for the character-class run matcher.
// No dependencies; used by every other file of the block.
`timescale 1ns / 1ps
`default_nettype none

package ccrm_pkg;

	localparam int CHAR_W     = 8;
	localparam int LEN_W      = 6;
	localparam int NUM_CLASS  = 11;
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 64;
	localparam int MAP_W      = 256;

	// largest run an attempt may reach, whatever length_set says
	localparam logic [LEN_W-1:0] MAX_RUN_LENGTH = 6'd63;

	// register indexes of the configuration port
	localparam logic [CFG_ADDR_W-1:0] REG_CHAR_SET_0 = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_CHAR_SET_1 = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_CHAR_SET_2 = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_CHAR_SET_3 = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_CLASS_EN   = 3'd4;
	localparam logic [CFG_ADDR_W-1:0] REG_LENGTH_SET = 3'd5;

	localparam logic [CFG_DATA_W-1:0] LENGTH_SET_RST = 64'd2;

	// ctype class bit positions
	localparam int CT_ALNUM  = 0;
	localparam int CT_ALPHA  = 1;
	localparam int CT_CNTRL  = 2;
	localparam int CT_DIGIT  = 3;
	localparam int CT_GRAPH  = 4;
	localparam int CT_LOWER  = 5;
	localparam int CT_PRINT  = 6;
	localparam int CT_PUNCT  = 7;
	localparam int CT_SPACE  = 8;
	localparam int CT_UPPER  = 9;
	localparam int CT_XDIGIT = 10;

	typedef struct packed {
		logic [MAP_W-1:0]      char_map;
		logic [NUM_CLASS-1:0]  class_en;
		logic [CFG_DATA_W-1:0] length_set;
		logic [LEN_W-1:0]      top_len;   // largest accepted length, capped
	} cfg_t;

	typedef struct packed {
		logic             empty_match;
		logic             prefix_match;
		logic [LEN_W-1:0] prefix_length;
		logic             finished;
	} result_t;

	// C-locale ctype membership; bytes above 127 are in no class
	function automatic logic [NUM_CLASS-1:0] ctype_mask(input logic [CHAR_W-1:0] c);
		logic up;
		logic lo;
		logic dg;
		logic gr;
		logic [NUM_CLASS-1:0] m;
		up = c inside {[8'h41:8'h5A]};
		lo = c inside {[8'h61:8'h7A]};
		dg = c inside {[8'h30:8'h39]};
		gr = c inside {[8'd33:8'd126]};
		m = '0;
		m[CT_ALNUM]  = up | lo | dg;
		m[CT_ALPHA]  = up | lo;
		m[CT_CNTRL]  = (c <= 8'd31) | (c == 8'd127);
		m[CT_DIGIT]  = dg;
		m[CT_GRAPH]  = gr;
		m[CT_LOWER]  = lo;
		m[CT_PRINT]  = c inside {[8'd32:8'd126]};
		m[CT_PUNCT]  = gr & ~(up | lo | dg);
		m[CT_SPACE]  = (c inside {[8'd9:8'd13]}) | (c == 8'd32);
		m[CT_UPPER]  = up;
		m[CT_XDIGIT] = dg | (c inside {[8'h41:8'h46]}) | (c inside {[8'h61:8'h66]});
		return m;
	endfunction

	// highest set bit of the length map, capped at MAX_RUN_LENGTH
	function automatic logic [LEN_W-1:0] top_length(input logic [CFG_DATA_W-1:0] v);
		logic [LEN_W-1:0] t;
		t = '0;
		for (int k = 0; k < CFG_DATA_W; k++) begin
			if (v[k]) begin
				t = LEN_W'(k);
			end
		end
		if (t > MAX_RUN_LENGTH) begin
			t = MAX_RUN_LENGTH;
		end
		return t;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/ccrm_cfg_regs.sv =====
// Configuration register file: character map, class enables, length map.
// Also keeps the precomputed maximum run length. Depends on ccrm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ccrm_cfg_regs (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [ccrm_pkg::CFG_ADDR_W-1:0]   cfg_addr,
	input  wire logic [ccrm_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	output ccrm_pkg::cfg_t                         cfg
);

	logic [ccrm_pkg::MAP_W-1:0]      char_map_q;
	logic [ccrm_pkg::NUM_CLASS-1:0]  class_en_q;
	logic [ccrm_pkg::CFG_DATA_W-1:0] length_set_q;
	logic [ccrm_pkg::LEN_W-1:0]      top_len_q;

	// top length follows the written value directly, so it is ready with the register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_map_q   <= '0;
			class_en_q   <= '0;
			length_set_q <= ccrm_pkg::LENGTH_SET_RST;
			top_len_q    <= ccrm_pkg::top_length(ccrm_pkg::LENGTH_SET_RST);
		end else if (cfg_we) begin
			case (cfg_addr)
				ccrm_pkg::REG_CHAR_SET_0: char_map_q[63:0]    <= cfg_wdata;
				ccrm_pkg::REG_CHAR_SET_1: char_map_q[127:64]  <= cfg_wdata;
				ccrm_pkg::REG_CHAR_SET_2: char_map_q[191:128] <= cfg_wdata;
				ccrm_pkg::REG_CHAR_SET_3: char_map_q[255:192] <= cfg_wdata;
				ccrm_pkg::REG_CLASS_EN:   class_en_q <= cfg_wdata[ccrm_pkg::NUM_CLASS-1:0];
				ccrm_pkg::REG_LENGTH_SET: begin
					length_set_q <= cfg_wdata;
					top_len_q    <= ccrm_pkg::top_length(cfg_wdata);
				end
				default: ;
			endcase
		end
	end

	assign cfg.char_map   = char_map_q;
	assign cfg.class_en   = class_en_q;
	assign cfg.length_set = length_set_q;
	assign cfg.top_len    = top_len_q;

endmodule

`default_nettype wire

// ===== rtl/ccrm_run.sv =====
// Class test and run-length tracking for one character per cycle while step is high.
// Holds run_count and attempt state. Depends on ccrm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ccrm_run (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           step,       // item leaves the input register
	input  wire logic [ccrm_pkg::CHAR_W-1:0]    char_code,
	input  wire logic                           start_req,
	input  ccrm_pkg::cfg_t                      cfg,
	output ccrm_pkg::result_t                   res,
	output logic                                active       // attempt running
);

	logic [ccrm_pkg::LEN_W-1:0] run_q;
	logic                       active_q;

	logic                       hit;
	logic                       act_eff;
	logic [ccrm_pkg::LEN_W-1:0] cnt;
	logic [ccrm_pkg::LEN_W-1:0] cnt_inc;
	logic [ccrm_pkg::LEN_W-1:0] run_d;
	logic                       active_d;

	assign hit = cfg.char_map[char_code]
		| (|(ccrm_pkg::ctype_mask(char_code) & cfg.class_en));

	always_comb begin
		act_eff  = start_req | active_q;
		cnt      = start_req ? '0 : run_q;
		cnt_inc  = cnt + 1'b1;
		run_d    = run_q;
		active_d = active_q;
		res      = '0;
		res.empty_match = start_req & cfg.length_set[0];
		if (act_eff) begin
			if ((cnt >= cfg.top_len) || !hit) begin
				res.finished = 1'b1;
				active_d     = 1'b0;
				run_d        = '0;
			end else begin
				run_d              = cnt_inc;
				active_d           = 1'b1;
				res.prefix_length  = cnt_inc;
				res.prefix_match   = cfg.length_set[cnt_inc];
				if (cnt_inc >= cfg.top_len) begin
					res.finished = 1'b1;
					active_d     = 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q    <= '0;
			active_q <= 1'b0;
		end else if (step) begin
			run_q    <= run_d;
			active_q <= active_d;
		end
	end

	assign active = active_q;

endmodule

`default_nettype wire

// ===== rtl/char_class_run_matcher_core.sv =====
// Top level of the character-class run matcher: stream ports, input and result registers.
// Instantiates ccrm_cfg_regs and ccrm_run; depends on ccrm_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Matches runs of bytes against a character class with a set of accepted
// run lengths, as in [set]{n,m,...}. A byte is in the class if its bit in
// the 256-bit character map is set or it falls in an enabled C-locale ctype
// class. A request with tuser = 1 starts an attempt; it reports whether
// length zero is accepted and tests its own byte as the first of the run.
// Every request gives exactly one result; tlast on the result marks the end
// of the attempt (mismatch, or the run reached the largest accepted length,
// capped at 63). The block takes one request per clock while the result
// side keeps up: a request is held in the input register, the class lookup
// and run counter update happen between that register and the result
// register, which drives the result stream. The maximum length is a priority
// encode of length_set done at configuration write time. Configuration must
// be written only while no request is in flight; the block does not
// enforce this. There is no read-back.
module char_class_run_matcher_core (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// configuration write port
	input  wire logic                             cfg_we,
	input  wire logic [ccrm_pkg::CFG_ADDR_W-1:0]  cfg_addr,
	input  wire logic [ccrm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	// request stream
	input  wire logic                             s_axis_tvalid,
	output logic                                  s_axis_tready,
	input  wire logic [7:0]                       s_axis_tdata,  // [7:0] char_code
	input  wire logic                             s_axis_tuser,  // [0] start_req
	// result stream
	output logic                                  m_axis_tvalid,
	input  wire logic                             m_axis_tready,
	// [0] empty_match, [1] prefix_match, [7:2] prefix_length
	output logic [7:0]                            m_axis_tdata,
	output logic                                  m_axis_tlast   // finished
);

	ccrm_pkg::cfg_t    cfg;
	ccrm_pkg::result_t run_res;
	ccrm_pkg::result_t res_q;

	logic                          valid_s1;
	logic [ccrm_pkg::CHAR_W-1:0]   char_s1;
	logic                          start_s1;
	logic                          out_valid_q;
	logic                          advance;
	logic                          in_acc;
	logic                          run_active;

	// item moves from the input register into the result register
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	ccrm_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata),
		.cfg      (cfg)
	);

	ccrm_run u_run (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (advance),
		.char_code(char_s1),
		.start_req(start_s1),
		.cfg      (cfg),
		.res      (run_res),
		.active   (run_active)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			char_s1  <= s_axis_tdata;
			start_s1 <= s_axis_tuser;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= run_res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {res_q.prefix_length, res_q.prefix_match, res_q.empty_match};
	assign m_axis_tlast  = res_q.finished;

	// an attempt that ends leaves no run behind
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && run_res.finished |=> !run_active)
		else $error("attempt still active after finish");

	// a stalled item stays in the input register
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(char_s1) && $stable(start_s1))
		else $error("input register lost a stalled request");

	// an accepted length always comes with a nonzero run
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.prefix_match |-> res_q.prefix_length != '0)
		else $error("prefix match with zero length");

endmodule

`default_nettype wire
